// ===== src/oad_pkg.sv =====
// Shared types, codes and limits for the obstacle-avoidance drive controller.
// No dependencies; used by oad_step and obstacle_avoid_drive_fsm_core.
`timescale 1ns / 1ps

package oad_pkg;

    // Fixed timing limits, in milliseconds
    localparam logic [31:0] STALE_LIMIT_MS    = 32'd100;
    localparam logic [31:0] TURN_MIN_MS       = 32'd300;
    localparam logic [31:0] JUNCTION_COOLDOWN = 32'd1000;

    // Car mode codes
    localparam logic [1:0] MODE_STOP   = 2'd0;
    localparam logic [1:0] MODE_MANUAL = 2'd1;

    // Motion command codes
    localparam logic [2:0] MV_STOP    = 3'd0;
    localparam logic [2:0] MV_FWD     = 3'd1;
    localparam logic [2:0] MV_BACK    = 3'd2;
    localparam logic [2:0] MV_ROT_L   = 3'd3;
    localparam logic [2:0] MV_ROT_R   = 3'd4;
    localparam logic [2:0] MV_CURVE_R = 3'd5;
    localparam logic [2:0] MV_CURVE_L = 3'd6;
    localparam logic [2:0] MV_NONE    = 3'd7;

    // Reported phase codes
    localparam logic [2:0] PH_FWD   = 3'd0;
    localparam logic [2:0] PH_PAUSE = 3'd1;
    localparam logic [2:0] PH_REV   = 3'd2;
    localparam logic [2:0] PH_TL    = 3'd3;
    localparam logic [2:0] PH_TR    = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_FRONT_STOP      = 3'd0;
    localparam logic [2:0] CFG_FRONT_CLEAR     = 3'd1;
    localparam logic [2:0] CFG_SIDE_OPEN       = 3'd2;
    localparam logic [2:0] CFG_SIDE_BLOCKED    = 3'd3;
    localparam logic [2:0] CFG_JUNCTION_MARGIN = 3'd4;
    localparam logic [2:0] CFG_PAUSE_TIME      = 3'd5;
    localparam logic [2:0] CFG_REVERSE_TIME    = 3'd6;
    localparam logic [2:0] CFG_TURN_MAX        = 3'd7;

    // Drive machine, one-hot
    typedef enum logic [4:0] {
        ST_FWD   = 5'b00001,
        ST_PAUSE = 5'b00010,
        ST_REV   = 5'b00100,
        ST_TL    = 5'b01000,
        ST_TR    = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] phase_start;
        logic [31:0] last_junction;
        logic        prefer_left;
    } drv_state_t;

    typedef struct packed {
        logic [15:0] stop_dist_mm;
        logic [15:0] clear_dist_mm;
        logic [15:0] branch_open_mm;
        logic [15:0] wall_near_mm;
        logic [15:0] junction_margin_mm;
        logic [31:0] pause_time_ms;
        logic [31:0] backup_time_ms;
        logic [31:0] turn_max_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  car_mode;
        logic [31:0] now_ms;
        logic [15:0] front_mm;
        logic [15:0] left_mm;
        logic [15:0] right_mm;
        logic        front_ok;
        logic        left_ok;
        logic        right_ok;
        logic [31:0] front_stamp_ms;
        logic [31:0] left_stamp_ms;
        logic [31:0] right_stamp_ms;
    } tick_t;

    typedef struct packed {
        logic [2:0] motion;
        logic [2:0] drive_phase;
    } result_t;

    // Map the one-hot phase onto its reported code
    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            ST_PAUSE: code = PH_PAUSE;
            ST_REV:   code = PH_REV;
            ST_TL:    code = PH_TL;
            ST_TR:    code = PH_TR;
            default:  code = PH_FWD;
        endcase
        return code;
    endfunction

endpackage

// ===== src/oad_step.sv =====
// One control tick of the drive machine: motion command and next state.
// Combinational; depends on oad_pkg.
`timescale 1ns / 1ps

module oad_step (
    input  oad_pkg::tick_t      tick,
    input  oad_pkg::cfg_t       cfg,
    input  oad_pkg::drv_state_t cur,
    output oad_pkg::drv_state_t nxt,
    output oad_pkg::result_t    res
);

    logic        fv, lv, rv;
    logic [31:0] el;
    logic [31:0] since_junction;
    logic [15:0] lim;
    logic        l_blocked, r_blocked;
    logic        pick_left;

    // Freshness of each reading, wrapping time differences
    assign fv = tick.front_ok &&
                ((tick.now_ms - tick.front_stamp_ms) <= oad_pkg::STALE_LIMIT_MS);
    assign lv = tick.left_ok &&
                ((tick.now_ms - tick.left_stamp_ms) <= oad_pkg::STALE_LIMIT_MS);
    assign rv = tick.right_ok &&
                ((tick.now_ms - tick.right_stamp_ms) <= oad_pkg::STALE_LIMIT_MS);

    assign el             = tick.now_ms - cur.phase_start;
    assign since_junction = tick.now_ms - cur.last_junction;
    assign lim            = tick.front_mm + cfg.junction_margin_mm;
    assign l_blocked      = !lv || (tick.left_mm < cfg.wall_near_mm);
    assign r_blocked      = !rv || (tick.right_mm < cfg.wall_near_mm);

    // Side choice: the wider fresh side, left when only left is fresh
    assign pick_left = (lv && rv) ? (tick.left_mm >= tick.right_mm) : lv;

    logic [2:0] mv;

    always_comb begin
        nxt = cur;
        mv  = oad_pkg::MV_STOP;
        if (tick.car_mode == oad_pkg::MODE_STOP || tick.car_mode == oad_pkg::MODE_MANUAL) begin
            nxt.phase         = oad_pkg::ST_FWD;
            nxt.phase_start   = tick.now_ms;
            nxt.last_junction = tick.now_ms;
            mv = (tick.car_mode == oad_pkg::MODE_STOP) ? oad_pkg::MV_STOP : oad_pkg::MV_NONE;
        end else if (!fv) begin
            // Stale front reading: hold everything and stop
            mv = oad_pkg::MV_STOP;
        end else begin
            case (cur.phase)
                oad_pkg::ST_FWD: begin
                    if (tick.front_mm <= cfg.stop_dist_mm) begin
                        mv              = oad_pkg::MV_STOP;
                        nxt.prefer_left = pick_left;
                        nxt.phase       = oad_pkg::ST_PAUSE;
                        nxt.phase_start = tick.now_ms;
                    end else if (since_junction >= oad_pkg::JUNCTION_COOLDOWN && lv && rv) begin
                        if (tick.left_mm >= cfg.branch_open_mm && tick.left_mm > lim &&
                            tick.left_mm > tick.right_mm) begin
                            mv                = oad_pkg::MV_ROT_L;
                            nxt.phase         = oad_pkg::ST_TL;
                            nxt.phase_start   = tick.now_ms;
                            nxt.last_junction = tick.now_ms;
                        end else if (tick.right_mm >= cfg.branch_open_mm && tick.right_mm > lim &&
                                     tick.right_mm > tick.left_mm) begin
                            mv                = oad_pkg::MV_ROT_R;
                            nxt.phase         = oad_pkg::ST_TR;
                            nxt.phase_start   = tick.now_ms;
                            nxt.last_junction = tick.now_ms;
                        end else if (tick.left_mm < cfg.wall_near_mm) begin
                            mv = oad_pkg::MV_CURVE_R;
                        end else if (tick.right_mm < cfg.wall_near_mm) begin
                            mv = oad_pkg::MV_CURVE_L;
                        end else begin
                            mv = oad_pkg::MV_FWD;
                        end
                    end else if (lv && tick.left_mm < cfg.wall_near_mm) begin
                        mv = oad_pkg::MV_CURVE_R;
                    end else if (rv && tick.right_mm < cfg.wall_near_mm) begin
                        mv = oad_pkg::MV_CURVE_L;
                    end else begin
                        mv = oad_pkg::MV_FWD;
                    end
                end
                oad_pkg::ST_PAUSE: begin
                    mv = oad_pkg::MV_STOP;
                    if (el >= cfg.pause_time_ms) begin
                        if (l_blocked && r_blocked) begin
                            mv        = oad_pkg::MV_BACK;
                            nxt.phase = oad_pkg::ST_REV;
                        end else if (cur.prefer_left) begin
                            mv        = oad_pkg::MV_ROT_L;
                            nxt.phase = oad_pkg::ST_TL;
                        end else begin
                            mv        = oad_pkg::MV_ROT_R;
                            nxt.phase = oad_pkg::ST_TR;
                        end
                        nxt.phase_start = tick.now_ms;
                    end
                end
                oad_pkg::ST_REV: begin
                    mv = oad_pkg::MV_BACK;
                    if (el >= cfg.backup_time_ms) begin
                        nxt.prefer_left = pick_left;
                        if (pick_left) begin
                            mv        = oad_pkg::MV_ROT_L;
                            nxt.phase = oad_pkg::ST_TL;
                        end else begin
                            mv        = oad_pkg::MV_ROT_R;
                            nxt.phase = oad_pkg::ST_TR;
                        end
                        nxt.phase_start = tick.now_ms;
                    end
                end
                oad_pkg::ST_TL, oad_pkg::ST_TR: begin
                    mv = (cur.phase == oad_pkg::ST_TL) ? oad_pkg::MV_ROT_L : oad_pkg::MV_ROT_R;
                    if ((el >= oad_pkg::TURN_MIN_MS && tick.front_mm >= cfg.clear_dist_mm) ||
                        el >= cfg.turn_max_ms) begin
                        mv                = oad_pkg::MV_STOP;
                        nxt.phase         = oad_pkg::ST_FWD;
                        nxt.phase_start   = tick.now_ms;
                        nxt.last_junction = tick.now_ms;
                    end
                end
                default: begin
                    mv                = oad_pkg::MV_STOP;
                    nxt.phase         = oad_pkg::ST_FWD;
                    nxt.phase_start   = tick.now_ms;
                    nxt.last_junction = tick.now_ms;
                end
            endcase
        end
    end

    assign res.motion      = mv;
    assign res.drive_phase = oad_pkg::phase_code(nxt.phase);

endmodule

// ===== src/obstacle_avoid_drive_fsm_core.sv =====
// Top level of the obstacle-avoidance drive controller: stream ports, config
// registers, request and result registers. Depends on oad_pkg and oad_step.
`timescale 1ns / 1ps

// Each request is one control tick; it yields exactly one result, the motion
// command and the drive phase after the step. A request is taken into an input
// register, evaluated by the combinational step logic against the held drive
// state, and the result lands in an output register while the state updates at
// the same edge. One request per clock is sustained while m_tready stays high;
// a request moves from the request register to the result register once that
// is empty or being read. The result register parts the two sides, so a new
// request is taken while a result waits, and only a stall on the result side
// with both registers full holds s_tready low. Configuration writes take effect
// on the next clock and should be made while no request is in flight.
module obstacle_avoid_drive_fsm_core (
    input  logic         aclk,
    input  logic         aresetn,
    // Request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // car_mode[1:0], now_ms[33:2], front_mm[49:34], left_mm[65:50],
    // right_mm[81:66], front_ok[82], left_ok[83], right_ok[84],
    // front_stamp_ms[116:85], left_stamp_ms[148:117], right_stamp_ms[180:149]
    input  logic [183:0] s_tdata,
    // Result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // motion[2:0], drive_phase[5:3]
    output logic [7:0]   m_tdata,
    // Configuration write port
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    oad_pkg::tick_t      tick_in;
    oad_pkg::tick_t      tick_reg;
    logic                in_valid_reg;
    oad_pkg::result_t    res_reg;
    oad_pkg::result_t    res_next;
    logic                out_valid_reg;
    oad_pkg::drv_state_t state_reg;
    oad_pkg::drv_state_t state_next;
    oad_pkg::cfg_t       cfg_reg;
    logic                advance;

    // Unpack the request word
    assign tick_in.car_mode       = s_tdata[1:0];
    assign tick_in.now_ms         = s_tdata[33:2];
    assign tick_in.front_mm       = s_tdata[49:34];
    assign tick_in.left_mm        = s_tdata[65:50];
    assign tick_in.right_mm       = s_tdata[81:66];
    assign tick_in.front_ok       = s_tdata[82];
    assign tick_in.left_ok        = s_tdata[83];
    assign tick_in.right_ok       = s_tdata[84];
    assign tick_in.front_stamp_ms = s_tdata[116:85];
    assign tick_in.left_stamp_ms  = s_tdata[148:117];
    assign tick_in.right_stamp_ms = s_tdata[180:149];

    // Advance when the held request can move into the result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    oad_step u_step (
        .tick (tick_reg),
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            tick_reg <= tick_in;
        end
    end

    // Result register and drive state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg           <= 1'b0;
            state_reg.phase         <= oad_pkg::ST_FWD;
            state_reg.phase_start   <= 32'd0;
            state_reg.last_junction <= 32'd0;
            state_reg.prefer_left   <= 1'b1;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
            state_reg     <= state_next;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stop_dist_mm       <= 16'd250;
            cfg_reg.clear_dist_mm      <= 16'd400;
            cfg_reg.branch_open_mm     <= 16'd500;
            cfg_reg.wall_near_mm       <= 16'd150;
            cfg_reg.junction_margin_mm <= 16'd200;
            cfg_reg.pause_time_ms      <= 32'd300;
            cfg_reg.backup_time_ms     <= 32'd500;
            cfg_reg.turn_max_ms        <= 32'd1500;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                oad_pkg::CFG_FRONT_STOP:      cfg_reg.stop_dist_mm       <= cfg_wdata[15:0];
                oad_pkg::CFG_FRONT_CLEAR:     cfg_reg.clear_dist_mm      <= cfg_wdata[15:0];
                oad_pkg::CFG_SIDE_OPEN:       cfg_reg.branch_open_mm     <= cfg_wdata[15:0];
                oad_pkg::CFG_SIDE_BLOCKED:    cfg_reg.wall_near_mm       <= cfg_wdata[15:0];
                oad_pkg::CFG_JUNCTION_MARGIN: cfg_reg.junction_margin_mm <= cfg_wdata[15:0];
                oad_pkg::CFG_PAUSE_TIME:      cfg_reg.pause_time_ms      <= cfg_wdata;
                oad_pkg::CFG_REVERSE_TIME:    cfg_reg.backup_time_ms     <= cfg_wdata;
                oad_pkg::CFG_TURN_MAX:        cfg_reg.turn_max_ms        <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg.drive_phase, res_reg.motion};

endmodule

// ===== tb/sv/obstacle_avoid_drive_fsm_core_test.sv =====
// Self-checking bench for obstacle_avoid_drive_fsm_core: directed and random control ticks
// are scored against a cycle-free predictor of the drive machine.
// Depends on oad_pkg and the RTL of obstacle_avoid_drive_fsm_core only.
`timescale 1ns / 1ps

module obstacle_avoid_drive_fsm_core_test;
    import oad_pkg::*;

    // Automatic mode codes (both values drive the machine)
    localparam logic [1:0] MODE_AUTO     = 2'd2;
    localparam logic [1:0] MODE_AUTO_ALT = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 200000;

    localparam cfg_t CFG_AT_RESET = '{
        stop_dist_mm:       16'd250,
        clear_dist_mm:      16'd400,
        branch_open_mm:     16'd500,
        wall_near_mm:       16'd150,
        junction_margin_mm: 16'd200,
        pause_time_ms:      32'd300,
        backup_time_ms:     32'd500,
        turn_max_ms:        32'd1500
    };

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // car_mode, now_ms, front_mm, left_mm, right_mm, front_ok, left_ok, right_ok,
    // front_stamp_ms, left_stamp_ms, right_stamp_ms (lowest bits first)
    logic [183:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // motion, drive_phase (lowest bits first)
    logic [7:0]   m_tdata;
    logic         cfg_wr_en;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_wdata;

    // Predicted drive state and register copy
    cfg_t        pred_cfg;
    logic [2:0]  pred_phase;
    logic [31:0] pred_phase_start;
    logic [31:0] pred_last_junction;
    logic        pred_prefer_left;

    result_t     expected_moves[$];
    tick_t       bus_tick;
    logic [31:0] clock_ms = 32'd0;
    int unsigned tx_idle_pct = 34;
    int unsigned rx_idle_pct = 49;
    int unsigned fault_count = 0;
    int unsigned results_checked = 0;
    int unsigned cycle_count = 0;
    logic [7:0]  motion_seen = '0;
    logic [7:0]  phase_seen = '0;

    obstacle_avoid_drive_fsm_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // A reading counts only when flagged valid and no older than the stale limit
    function automatic logic reading_fresh(logic ok, logic [31:0] now, logic [31:0] stamp);
        logic [31:0] age;
        age = now - stamp;
        return ok && (age <= STALE_LIMIT_MS);
    endfunction

    // Side to favour: the wider one when both are fresh, else whichever is fresh
    function automatic logic side_pick(logic lv, logic rv, logic [15:0] l, logic [15:0] r);
        return (lv && rv) ? (l >= r) : lv;
    endfunction

    // Advance the predicted drive machine by one tick and return its command
    function automatic result_t drive_step(tick_t t);
        logic        fv, lv, rv, lb, rb;
        logic [31:0] el;
        logic [15:0] lim;
        logic [2:0]  mv;
        result_t     res;
        fv = reading_fresh(t.front_ok, t.now_ms, t.front_stamp_ms);
        lv = reading_fresh(t.left_ok, t.now_ms, t.left_stamp_ms);
        rv = reading_fresh(t.right_ok, t.now_ms, t.right_stamp_ms);
        el = t.now_ms - pred_phase_start;
        mv = MV_STOP;
        if (t.car_mode == MODE_STOP || t.car_mode == MODE_MANUAL) begin
            pred_phase = PH_FWD;
            pred_phase_start = t.now_ms;
            pred_last_junction = t.now_ms;
            mv = (t.car_mode == MODE_STOP) ? MV_STOP : MV_NONE;
        end else if (!fv) begin
            mv = MV_STOP;
        end else begin
            case (pred_phase)
                PH_FWD: begin
                    if (t.front_mm <= pred_cfg.stop_dist_mm) begin
                        mv = MV_STOP;
                        pred_prefer_left = side_pick(lv, rv, t.left_mm, t.right_mm);
                        pred_phase = PH_PAUSE;
                        pred_phase_start = t.now_ms;
                    end else if ((t.now_ms - pred_last_junction) >= JUNCTION_COOLDOWN
                                 && lv && rv) begin
                        // junction limit wraps at 16 bits
                        lim = t.front_mm + pred_cfg.junction_margin_mm;
                        if (t.left_mm >= pred_cfg.branch_open_mm && t.left_mm > lim
                            && t.left_mm > t.right_mm) begin
                            mv = MV_ROT_L;
                            pred_phase = PH_TL;
                            pred_phase_start = t.now_ms;
                            pred_last_junction = t.now_ms;
                        end else if (t.right_mm >= pred_cfg.branch_open_mm && t.right_mm > lim
                                     && t.right_mm > t.left_mm) begin
                            mv = MV_ROT_R;
                            pred_phase = PH_TR;
                            pred_phase_start = t.now_ms;
                            pred_last_junction = t.now_ms;
                        end else if (t.left_mm < pred_cfg.wall_near_mm) begin
                            mv = MV_CURVE_R;
                        end else if (t.right_mm < pred_cfg.wall_near_mm) begin
                            mv = MV_CURVE_L;
                        end else begin
                            mv = MV_FWD;
                        end
                    end else if (lv && t.left_mm < pred_cfg.wall_near_mm) begin
                        mv = MV_CURVE_R;
                    end else if (rv && t.right_mm < pred_cfg.wall_near_mm) begin
                        mv = MV_CURVE_L;
                    end else begin
                        mv = MV_FWD;
                    end
                end
                PH_PAUSE: begin
                    mv = MV_STOP;
                    if (el >= pred_cfg.pause_time_ms) begin
                        lb = !lv || t.left_mm < pred_cfg.wall_near_mm;
                        rb = !rv || t.right_mm < pred_cfg.wall_near_mm;
                        if (lb && rb) begin
                            mv = MV_BACK;
                            pred_phase = PH_REV;
                        end else if (pred_prefer_left) begin
                            mv = MV_ROT_L;
                            pred_phase = PH_TL;
                        end else begin
                            mv = MV_ROT_R;
                            pred_phase = PH_TR;
                        end
                        pred_phase_start = t.now_ms;
                    end
                end
                PH_REV: begin
                    mv = MV_BACK;
                    if (el >= pred_cfg.backup_time_ms) begin
                        pred_prefer_left = side_pick(lv, rv, t.left_mm, t.right_mm);
                        if (pred_prefer_left) begin
                            mv = MV_ROT_L;
                            pred_phase = PH_TL;
                        end else begin
                            mv = MV_ROT_R;
                            pred_phase = PH_TR;
                        end
                        pred_phase_start = t.now_ms;
                    end
                end
                PH_TL, PH_TR: begin
                    mv = (pred_phase == PH_TL) ? MV_ROT_L : MV_ROT_R;
                    if ((el >= TURN_MIN_MS && t.front_mm >= pred_cfg.clear_dist_mm)
                        || el >= pred_cfg.turn_max_ms) begin
                        mv = MV_STOP;
                        pred_phase = PH_FWD;
                        pred_phase_start = t.now_ms;
                        pred_last_junction = t.now_ms;
                    end
                end
                default: begin
                    mv = MV_STOP;
                    pred_phase = PH_FWD;
                    pred_phase_start = t.now_ms;
                    pred_last_junction = t.now_ms;
                end
            endcase
        end
        res.motion = mv;
        res.drive_phase = pred_phase;
        return res;
    endfunction

    // Score: predict each accepted request, compare each accepted result
    always @(posedge aclk) begin : score
        result_t want;
        if (aresetn && s_tvalid && s_tready) begin
            expected_moves.push_back(drive_step(bus_tick));
        end
        if (aresetn && m_tvalid && m_tready) begin
            motion_seen[m_tdata[2:0]] = 1'b1;
            phase_seen[m_tdata[5:3]] = 1'b1;
            if (expected_moves.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("unexpected result %h with nothing outstanding", m_tdata);
                end
            end else begin
                want = expected_moves.pop_front();
                if (m_tdata[2:0] !== want.motion || m_tdata[5:3] !== want.drive_phase) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("result %0d: motion exp %0d got %0d, phase exp %0d got %0d",
                                 results_checked, want.motion, m_tdata[2:0],
                                 want.drive_phase, m_tdata[5:3]);
                    end
                end
            end
            results_checked++;
        end
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Hand one tick over, idling first at random; returns at the accepting edge
    task automatic send_tick(tick_t t);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, t.right_stamp_ms, t.left_stamp_ms, t.front_stamp_ms,
                     t.right_ok, t.left_ok, t.front_ok, t.right_mm, t.left_mm,
                     t.front_mm, t.now_ms, t.car_mode};
        bus_tick <= t;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid and hold until every predicted result is back, then let the pipe empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_moves.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all eight registers; 16-bit ones carry junk in the upper half
    task automatic apply_cfg(cfg_t c);
        logic [31:0] word [8];
        word[CFG_FRONT_STOP]      = {16'($urandom), c.stop_dist_mm};
        word[CFG_FRONT_CLEAR]     = {16'($urandom), c.clear_dist_mm};
        word[CFG_SIDE_OPEN]       = {16'($urandom), c.branch_open_mm};
        word[CFG_SIDE_BLOCKED]    = {16'($urandom), c.wall_near_mm};
        word[CFG_JUNCTION_MARGIN] = {16'($urandom), c.junction_margin_mm};
        word[CFG_PAUSE_TIME]      = c.pause_time_ms;
        word[CFG_REVERSE_TIME]    = c.backup_time_ms;
        word[CFG_TURN_MAX]        = c.turn_max_ms;
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= word[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        pred_cfg = c;
        @(posedge aclk);
    endtask

    // Tick with every sensor valid and just updated
    function automatic tick_t directed_tick(logic [1:0] mode, logic [31:0] now,
                                            logic [15:0] f, logic [15:0] l, logic [15:0] r);
        tick_t t;
        t.car_mode = mode;
        t.now_ms = now;
        t.front_mm = f;
        t.left_mm = l;
        t.right_mm = r;
        t.front_ok = 1'b1;
        t.left_ok = 1'b1;
        t.right_ok = 1'b1;
        t.front_stamp_ms = now - 32'd5;
        t.left_stamp_ms = now - 32'd5;
        t.right_stamp_ms = now - 32'd5;
        return t;
    endfunction

    function automatic logic [15:0] rand_dist();
        case ($urandom_range(9))
            0:          return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1, 2, 3, 4: return 16'($urandom_range(700));
            9:          return 16'($urandom);
            default:    return 16'($urandom_range(2000));
        endcase
    endfunction

    // Mostly fresh readings, some just stale, a few from anywhere (future stamps too)
    function automatic logic [31:0] rand_age();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 90) return $urandom_range(STALE_LIMIT_MS);
        if (roll < 97) return $urandom_range(STALE_LIMIT_MS + 300, STALE_LIMIT_MS + 1);
        return $urandom();
    endfunction

    // Realistic drive traffic: time moves on by a control period, rare jumps and mode drops
    function automatic tick_t random_tick();
        tick_t       t;
        int unsigned roll;
        if ($urandom_range(99) < 3) begin
            clock_ms = $urandom();
        end else begin
            clock_ms = clock_ms + $urandom_range(60, 10);
        end
        roll = $urandom_range(999);
        t.car_mode = (roll < 15) ? MODE_STOP : (roll < 30) ? MODE_MANUAL :
                     (roll < 80) ? MODE_AUTO_ALT : MODE_AUTO;
        t.now_ms = clock_ms;
        t.front_mm = rand_dist();
        t.left_mm = rand_dist();
        t.right_mm = ($urandom_range(19) == 0) ? t.left_mm : rand_dist();
        t.front_ok = ($urandom_range(99) < 96);
        t.left_ok = ($urandom_range(99) < 94);
        t.right_ok = ($urandom_range(99) < 94);
        t.front_stamp_ms = clock_ms - rand_age();
        t.left_stamp_ms = clock_ms - rand_age();
        t.right_stamp_ms = clock_ms - rand_age();
        return t;
    endfunction

    task automatic run_traffic(int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            send_tick(random_tick());
        end
    endtask

    // Modes, staleness, every phase, junction wrap and time wrap at reset values
    task automatic test_directed();
        tick_t t;
        send_tick(directed_tick(MODE_STOP, 32'd1000, 16'd1000, 16'd300, 16'd300));
        send_tick(directed_tick(MODE_MANUAL, 32'd1030, 16'd1000, 16'd300, 16'd300));
        send_tick(directed_tick(MODE_AUTO_ALT, 32'd1060, 16'd1000, 16'd300, 16'd300));
        send_tick(directed_tick(MODE_AUTO, 32'd1090, 16'd1000, 16'd100, 16'd300));
        send_tick(directed_tick(MODE_AUTO, 32'd1120, 16'd1000, 16'd300, 16'd100));
        // front reading too old, then front flagged invalid
        t = directed_tick(MODE_AUTO, 32'd1150, 16'd100, 16'd300, 16'd300);
        t.front_stamp_ms = 32'd1150 - STALE_LIMIT_MS - 32'd1;
        send_tick(t);
        t = directed_tick(MODE_AUTO, 32'd1180, 16'd100, 16'd300, 16'd300);
        t.front_ok = 1'b0;
        send_tick(t);
        // junction turns left, ends on clear front; then right, ends on time-out
        send_tick(directed_tick(MODE_AUTO, 32'd2100, 16'd600, 16'd900, 16'd700));
        send_tick(directed_tick(MODE_AUTO, 32'd2200, 16'd1000, 16'd900, 16'd700));
        send_tick(directed_tick(MODE_AUTO, 32'd2400, 16'd450, 16'd300, 16'd300));
        send_tick(directed_tick(MODE_AUTO, 32'd3500, 16'd600, 16'd700, 16'd900));
        send_tick(directed_tick(MODE_AUTO, 32'd5100, 16'd100, 16'd300, 16'd300));
        // obstacle: pause, then turn towards the wider side
        send_tick(directed_tick(MODE_AUTO, 32'd5130, 16'd250, 16'd0, 16'hFFFF));
        send_tick(directed_tick(MODE_AUTO, 32'd5200, 16'd200, 16'd0, 16'hFFFF));
        send_tick(directed_tick(MODE_AUTO, 32'd5430, 16'd200, 16'd400, 16'hFFFF));
        send_tick(directed_tick(MODE_AUTO, 32'd5730, 16'd400, 16'd300, 16'd300));
        // boxed in: pause, reverse, then turn to the only fresh side
        send_tick(directed_tick(MODE_AUTO, 32'd5760, 16'd0, 16'd100, 16'd100));
        t = directed_tick(MODE_AUTO, 32'd6060, 16'd0, 16'd100, 16'd400);
        t.right_stamp_ms = 32'd6060 - 32'd150;
        send_tick(t);
        t = directed_tick(MODE_AUTO, 32'd6560, 16'd0, 16'd900, 16'd200);
        t.left_ok = 1'b0;
        send_tick(t);
        send_tick(directed_tick(MODE_AUTO, 32'd6900, 16'd500, 16'd300, 16'd300));
        // junction limit wraps past 16 bits
        send_tick(directed_tick(MODE_AUTO, 32'd8000, 16'hFFFF, 16'd600, 16'd550));
        // millisecond clock wraps; a stamp ahead of the clock counts as stale
        send_tick(directed_tick(MODE_STOP, 32'hFFFF_FFF0, 16'd1000, 16'd300, 16'd300));
        t = directed_tick(MODE_AUTO, 32'h0000_0010, 16'd1000, 16'd300, 16'd300);
        t.front_stamp_ms = 32'hFFFF_FFF0;
        send_tick(t);
        t = directed_tick(MODE_AUTO, 32'h0000_0020, 16'd1000, 16'd300, 16'd300);
        t.front_stamp_ms = 32'h0000_0021;
        send_tick(t);
        // equal open sides at a junction: no turn
        send_tick(directed_tick(MODE_AUTO, 32'd1100, 16'd300, 16'd800, 16'd800));
        settle();
    endtask

    task automatic test_default_traffic();
        run_traffic(200);
        settle();
    endtask

    task automatic test_zero_limits();
        apply_cfg('0);
        run_traffic(100);
        settle();
    endtask

    task automatic test_max_limits();
        apply_cfg('1);
        run_traffic(60);
        settle();
    endtask

    task automatic test_mixed_limits();
        cfg_t c;
        for (int k = 0; k < 3; k++) begin
            c.stop_dist_mm       = 16'($urandom_range(600));
            c.clear_dist_mm      = 16'($urandom_range(1200));
            c.branch_open_mm     = 16'($urandom_range(1500));
            c.wall_near_mm       = 16'($urandom_range(400));
            c.junction_margin_mm = 16'($urandom_range(600));
            c.pause_time_ms      = $urandom_range(800);
            c.backup_time_ms     = $urandom_range(1000);
            c.turn_max_ms        = $urandom_range(2500);
            apply_cfg(c);
            run_traffic(105);
            settle();
        end
    endtask

    // Abort a hung run
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("obstacle_avoid_drive_fsm_core verification failed");
        $finish;
    end

    initial begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        bus_tick  <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        pred_cfg = CFG_AT_RESET;
        pred_phase = PH_FWD;
        pred_phase_start = '0;
        pred_last_junction = '0;
        pred_prefer_left = 1'b1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 34;
        rx_idle_pct = 49;
        test_directed();
        test_default_traffic();
        tx_idle_pct = 49;
        rx_idle_pct = 34;
        test_zero_limits();
        test_max_limits();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_mixed_limits();

        $display("Checked %0d ticks under reset, zero, full-scale and three random limit sets.",
                 results_checked);
        $display("Motion codes seen %b, phases seen %b, faults %0d.",
                 motion_seen, phase_seen, fault_count);
        if (fault_count == 0) begin
            $display("obstacle_avoid_drive_fsm_core verification clean");
        end else begin
            $display("obstacle_avoid_drive_fsm_core verification failed");
        end
        $finish;
    end

endmodule
